// File: hdl/ipv4_header_receive_check_assert.svh
// ----------------------------------------------------------------------------
// IPv4 header receive check: assertion macros
// Shared assertion forms, clocked on a rising edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_RECEIVE_CHECK_ASSERT_SVH
`define IPV4_HEADER_RECEIVE_CHECK_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define IHRC_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define IHRC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define IHRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ihrc_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 header receive check package
// Word types, verdict codes and sizing constants shared by all modules.
// ----------------------------------------------------------------------------
package ihrc_pkg;

  localparam int unsigned MIN_HEADER_BYTES = 20;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned QUEUE_PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] COUNT_MAX   = 16'hffff;
  localparam logic [15:0] SUM_GOOD    = 16'hffff;
  localparam logic [3:0]  IP_VERSION4 = 4'd4;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;

  localparam logic [2:0] VERDICT_ICMP      = 3'd0;
  localparam logic [2:0] VERDICT_OTHER     = 3'd1;
  localparam logic [2:0] VERDICT_SHORT     = 3'd2;
  localparam logic [2:0] VERDICT_VERSION   = 3'd3;
  localparam logic [2:0] VERDICT_HDR_LEN   = 3'd4;
  localparam logic [2:0] VERDICT_CHECKSUM  = 3'd5;
  localparam logic [2:0] VERDICT_NOT_OURS  = 3'd6;
  localparam logic [2:0] VERDICT_TOTAL_LEN = 3'd7;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic        learn_mapping;
    logic [31:0] source_addr;
    logic [7:0]  protocol;
    logic [15:0] payload_len;
  } out_word_t;

  // Everything the checks need about one finished packet.
  typedef struct packed {
    logic [15:0] pkt_len;
    logic [3:0]  version;
    logic [3:0]  header_words;
    logic [15:0] total_length;
    logic [15:0] sum;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
  } pkt_summary_t;

endpackage

// File: hdl/ihrc_front.sv
// ----------------------------------------------------------------------------
// IPv4 header receive check: front end
// Takes one byte per cycle unless the queue is full, captures header fields,
// keeps the header checksum, and on the final byte passes a packet summary to it.
// ----------------------------------------------------------------------------
`include "ipv4_header_receive_check_assert.svh"

module ihrc_front import ihrc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  in_word_t     in_word_i,
  input  logic         q_full_i,
  output logic         full_o,
  output logic         q_push_o,
  output pkt_summary_t q_data_o
);

  logic [15:0] byte_count_q, byte_count_d;
  logic [15:0] sum_accum_q, sum_accum_d;
  logic [7:0]  high_byte_hold_q, high_byte_hold_d;
  logic [3:0]  version_q, version_d;
  logic [3:0]  header_words_q, header_words_d;
  logic [15:0] total_length_q, total_length_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;

  logic        accept;
  logic [15:0] idx;
  logic [7:0]  b;
  logic [5:0]  hdr_bytes;
  logic        in_hdr;
  logic [16:0] sum_wide;
  logic [15:0] count_upd;
  logic [15:0] sum_upd;
  logic [7:0]  hold_upd;
  logic [3:0]  version_upd;
  logic [3:0]  hw_upd;
  logic [15:0] total_upd;
  logic [7:0]  proto_upd;
  logic [31:0] src_upd;
  logic [31:0] dst_upd;

  // A packet can only end while the queue has room for its summary.
  assign full_o = q_full_i;
  assign accept = push_i && !q_full_i;

  assign idx       = byte_count_q;
  assign b         = in_word_i.frame_byte;
  assign hdr_bytes = {header_words_q, 2'b00};
  assign in_hdr    = (idx == 16'd0) || (idx < {10'd0, hdr_bytes});
  assign count_upd = (idx == COUNT_MAX) ? idx : idx + 16'd1;

  // Ones' complement add: a carry out wraps around into bit zero.
  assign sum_wide = {1'b0, sum_accum_q} + {1'b0, high_byte_hold_q, b};

  always_comb begin
    version_upd = version_q;
    hw_upd      = header_words_q;
    total_upd   = total_length_q;
    proto_upd   = proto_q;
    src_upd     = src_q;
    dst_upd     = dst_q;
    hold_upd    = high_byte_hold_q;
    sum_upd     = sum_accum_q;

    case (idx)
      16'd0: begin
        version_upd = b[7:4];
        hw_upd      = b[3:0];
      end
      16'd2:  total_upd[15:8] = b;
      16'd3:  total_upd[7:0]  = b;
      16'd9:  proto_upd       = b;
      16'd12: src_upd[31:24]  = b;
      16'd13: src_upd[23:16]  = b;
      16'd14: src_upd[15:8]   = b;
      16'd15: src_upd[7:0]    = b;
      16'd16: dst_upd[31:24]  = b;
      16'd17: dst_upd[23:16]  = b;
      16'd18: dst_upd[15:8]   = b;
      16'd19: dst_upd[7:0]    = b;
      default: ;
    endcase

    if (in_hdr) begin
      if (!idx[0]) begin
        hold_upd = b;
      end else begin
        sum_upd = sum_wide[15:0] + {15'd0, sum_wide[16]};
      end
    end
  end

  always_comb begin
    byte_count_d     = byte_count_q;
    sum_accum_d      = sum_accum_q;
    high_byte_hold_d = high_byte_hold_q;
    version_d        = version_q;
    header_words_d   = header_words_q;
    total_length_d   = total_length_q;
    proto_d          = proto_q;
    src_d            = src_q;
    dst_d            = dst_q;
    if (accept) begin
      if (in_word_i.is_last) begin
        byte_count_d     = '0;
        sum_accum_d      = '0;
        high_byte_hold_d = '0;
        version_d        = '0;
        header_words_d   = '0;
        total_length_d   = '0;
        proto_d          = '0;
        src_d            = '0;
        dst_d            = '0;
      end else begin
        byte_count_d     = count_upd;
        sum_accum_d      = sum_upd;
        high_byte_hold_d = hold_upd;
        version_d        = version_upd;
        header_words_d   = hw_upd;
        total_length_d   = total_upd;
        proto_d          = proto_upd;
        src_d            = src_upd;
        dst_d            = dst_upd;
      end
    end
  end

  assign q_push_o              = accept && in_word_i.is_last;
  assign q_data_o.pkt_len      = count_upd;
  assign q_data_o.version      = version_upd;
  assign q_data_o.header_words = hw_upd;
  assign q_data_o.total_length = total_upd;
  assign q_data_o.sum          = sum_upd;
  assign q_data_o.proto        = proto_upd;
  assign q_data_o.src          = src_upd;
  assign q_data_o.dst          = dst_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q     <= '0;
      sum_accum_q      <= '0;
      high_byte_hold_q <= '0;
      version_q        <= '0;
      header_words_q   <= '0;
      total_length_q   <= '0;
      proto_q          <= '0;
      src_q            <= '0;
      dst_q            <= '0;
    end else begin
      byte_count_q     <= byte_count_d;
      sum_accum_q      <= sum_accum_d;
      high_byte_hold_q <= high_byte_hold_d;
      version_q        <= version_d;
      header_words_q   <= header_words_d;
      total_length_q   <= total_length_d;
      proto_q          <= proto_d;
      src_q            <= src_d;
      dst_q            <= dst_d;
    end
  end

  `IHRC_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, q_push_o, (byte_count_q == 16'd0) && (sum_accum_q == 16'd0), "packet state not cleared after final byte")
  `IHRC_ASSERT_IMPL(a_push_only_accepted, clk_i, rst_ni, q_push_o, !q_full_i, "summary pushed into a full queue")

endmodule

// File: hdl/ihrc_queue.sv
// ----------------------------------------------------------------------------
// IPv4 header receive check: summary queue
// Short register queue between the front end and the verdict stage.
// ----------------------------------------------------------------------------
`include "ipv4_header_receive_check_assert.svh"

module ihrc_queue import ihrc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  pkt_summary_t wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output pkt_summary_t rdata_o
);

  pkt_summary_t           entries_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_push;
  logic                   do_pop;

  assign full_o  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entries_q[rd_ptr_q];

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    logic [QUEUE_PTR_W-1:0] r;
    if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QUEUE_PTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

  `IHRC_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

// File: hdl/ihrc_back.sv
// ----------------------------------------------------------------------------
// IPv4 header receive check: verdict stage
// Runs the header checks on a packet summary and holds the result word
// in an output register until it is popped.
// ----------------------------------------------------------------------------
`include "ipv4_header_receive_check_assert.svh"

module ihrc_back import ihrc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [31:0]  local_addr_i,
  input  logic         q_empty_i,
  input  pkt_summary_t q_data_i,
  output logic         q_pop_o,
  output logic         empty_o,
  input  logic         pop_i,
  output out_word_t    out_word_o
);

  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;
  out_word_t res;
  logic      take;
  logic [15:0] ihl;
  logic [15:0] min_hdr;
  logic      held_learn;
  logic      held_payload;
  logic      accept_ok;
  logic      learn_ok;
  logic      stall_hold;

  assign take    = !q_empty_i && (!out_valid_q || pop_i);
  assign q_pop_o = take;
  assign empty_o = !out_valid_q;
  assign out_word_o = out_q;

  assign ihl     = {10'd0, q_data_i.header_words, 2'b00};
  assign min_hdr = 16'(MIN_HEADER_BYTES);

  always_comb begin
    res.verdict       = VERDICT_OTHER;
    res.learn_mapping = 1'b0;
    res.source_addr   = q_data_i.src;
    res.protocol      = q_data_i.proto;
    res.payload_len   = '0;
    if (q_data_i.pkt_len < min_hdr) begin
      res.verdict = VERDICT_SHORT;
    end else if (q_data_i.version != IP_VERSION4) begin
      res.verdict = VERDICT_VERSION;
    end else if ((ihl < min_hdr) || (q_data_i.pkt_len < ihl)) begin
      res.verdict = VERDICT_HDR_LEN;
    end else if (q_data_i.sum != SUM_GOOD) begin
      res.verdict = VERDICT_CHECKSUM;
    end else begin
      res.learn_mapping = 1'b1;
      if (q_data_i.dst != local_addr_i) begin
        res.verdict = VERDICT_NOT_OURS;
      end else if ((q_data_i.total_length < ihl) ||
                   (q_data_i.total_length > q_data_i.pkt_len)) begin
        res.verdict = VERDICT_TOTAL_LEN;
      end else begin
        res.payload_len = q_data_i.total_length - ihl;
        res.verdict = (q_data_i.proto == PROTO_ICMP) ? VERDICT_ICMP : VERDICT_OTHER;
      end
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (take) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign held_learn   = out_valid_q && out_q.learn_mapping;
  assign held_payload = out_valid_q && (out_q.payload_len != 16'd0);
  assign accept_ok    = (out_q.verdict == VERDICT_ICMP) || (out_q.verdict == VERDICT_OTHER);
  assign learn_ok     = accept_ok || (out_q.verdict == VERDICT_NOT_OURS) ||
                        (out_q.verdict == VERDICT_TOTAL_LEN);
  assign stall_hold   = out_valid_q && !pop_i;

  `IHRC_ASSERT_IMPL(a_learn_verdict, clk_i, rst_ni, held_learn, learn_ok, "learn on bad header")
  `IHRC_ASSERT_IMPL(a_payload_ok, clk_i, rst_ni, held_payload, accept_ok, "payload on reject")
  `IHRC_ASSERT_NEXT(a_hold, clk_i, rst_ni, stall_hold, $stable({out_valid_q, out_q}), "word lost")

endmodule

// File: hdl/ipv4_header_receive_check.sv
// ----------------------------------------------------------------------------
// IPv4 header receive check
// Byte-stream IPv4 header validation with a queue interface on both sides.
// ----------------------------------------------------------------------------
// The block takes one packet byte per clock cycle while full is low, with no gaps
// needed between packets, and gives one result word for each byte marked as last.
// The per-byte work is a single 16-bit ones' complement add and field capture,
// which is what sets the one-byte-per-cycle rate. A final byte's summary is written
// to the queue, then its result word to the output register for popping.
// Packet summaries wait in a two-entry queue before the verdict stage, so the input
// keeps flowing while results are not being popped; full rises only once that queue
// is full. The local address should be written while no packet is in flight.
module ipv4_header_receive_check import ihrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_word_t    in_word_i,
  output logic        empty,
  input  logic        pop,
  output out_word_t   out_word_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0]  local_addr_q;
  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_empty;
  pkt_summary_t q_wdata;
  pkt_summary_t q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
    end else if (cfg_we_i) begin
      local_addr_q <= cfg_wdata_i;
    end
  end

  ihrc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_word_i (in_word_i),
    .q_full_i  (q_full),
    .full_o    (full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  ihrc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  ihrc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .local_addr_i (local_addr_q),
    .q_empty_i    (q_empty),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_word_o   (out_word_o)
  );

endmodule

// File: tb/ipv4_header_receive_check_tb.sv
// ----------------------------------------------------------------------------
// IPv4 header receive check testbench
// Streams IPv4 frames, good and broken, into the block one byte word at a
// time. A local predictor works out each verdict word, and every popped word
// is checked field by field. Both sides idle at random, and the local address
// is rewritten between phases.
// ----------------------------------------------------------------------------
module ipv4_header_receive_check_tb;
  import ihrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  in_word_t    in_word     = '0;
  logic        empty;
  logic        pop         = 1'b0;
  out_word_t   out_word;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  ipv4_header_receive_check u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Byte words waiting to be pushed, and verdict words still owed by the block.
  in_word_t    frame_bytes_q[$];
  out_word_t   verdicts_due[$];
  logic [7:0]  pkt_bytes[$];

  // Predicted per-frame state and the local address the block should hold.
  logic [31:0] our_addr    = '0;
  logic [15:0] rx_count    = '0;
  logic [15:0] rx_sum      = '0;
  logic [7:0]  rx_hold     = '0;
  logic [3:0]  rx_version  = '0;
  logic [3:0]  rx_ihl      = '0;
  logic [15:0] rx_total    = '0;
  logic [7:0]  rx_proto    = '0;
  logic [31:0] rx_src      = '0;
  logic [31:0] rx_dst      = '0;

  int unsigned mismatches    = 0;
  int unsigned cycles        = 0;
  int unsigned bytes_taken   = 0;
  int unsigned frames_queued = 0;
  int unsigned bytes_queued  = 0;
  int unsigned longest_frame = 0;
  int unsigned addr_settings = 1;
  int unsigned verdict_seen[8] = '{default: 0};

  logic        byte_taken    = 1'b0;
  int unsigned burst_left    = 0;
  int unsigned gap_left      = 0;
  int unsigned stall_left    = 0;
  int unsigned rx_mode       = 0;
  int unsigned rx_mode_left  = 0;

  function automatic void take_frame_byte(in_word_t w);
    int unsigned idx, hdr_len, acc;
    out_word_t   res;
    idx     = rx_count;
    hdr_len = rx_ihl * 4;
    if (idx == 0) begin
      rx_version = w.frame_byte[7:4];
      rx_ihl     = w.frame_byte[3:0];
    end else if (idx == 2) begin
      rx_total[15:8] = w.frame_byte;
    end else if (idx == 3) begin
      rx_total[7:0] = w.frame_byte;
    end else if (idx == 9) begin
      rx_proto = w.frame_byte;
    end else if (idx >= 12 && idx <= 15) begin
      rx_src[8 * (15 - idx) +: 8] = w.frame_byte;
    end else if (idx >= 16 && idx <= 19) begin
      rx_dst[8 * (19 - idx) +: 8] = w.frame_byte;
    end
    // The first byte is always summed; later ones only inside the header length
    // known before this byte arrived.
    if (idx == 0 || idx < hdr_len) begin
      if (idx[0] == 1'b0) begin
        rx_hold = w.frame_byte;
      end else begin
        acc = rx_sum + {rx_hold, w.frame_byte};
        if (acc > 32'hffff) acc -= 32'hffff;
        rx_sum = 16'(acc);
      end
    end
    if (rx_count != COUNT_MAX) rx_count++;
    if (w.is_last) begin
      hdr_len           = rx_ihl * 4;
      res               = '0;
      res.source_addr   = rx_src;
      res.protocol      = rx_proto;
      if (rx_count < MIN_HEADER_BYTES) begin
        res.verdict = VERDICT_SHORT;
      end else if (rx_version != IP_VERSION4) begin
        res.verdict = VERDICT_VERSION;
      end else if (hdr_len < MIN_HEADER_BYTES || rx_count < hdr_len) begin
        res.verdict = VERDICT_HDR_LEN;
      end else if (rx_sum != SUM_GOOD) begin
        res.verdict = VERDICT_CHECKSUM;
      end else begin
        res.learn_mapping = 1'b1;
        if (rx_dst != our_addr) begin
          res.verdict = VERDICT_NOT_OURS;
        end else if (rx_total < hdr_len || rx_total > rx_count) begin
          res.verdict = VERDICT_TOTAL_LEN;
        end else begin
          res.payload_len = 16'(rx_total - hdr_len);
          res.verdict     = (rx_proto == PROTO_ICMP) ? VERDICT_ICMP : VERDICT_OTHER;
        end
      end
      verdicts_due.push_back(res);
      rx_count   = '0;
      rx_sum     = '0;
      rx_hold    = '0;
      rx_version = '0;
      rx_ihl     = '0;
      rx_total   = '0;
      rx_proto   = '0;
      rx_src     = '0;
      rx_dst     = '0;
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin : drive_bytes
    logic     next_push;
    in_word_t next_word;
    next_push = push;
    next_word = in_word;
    if (rst_ni) begin
      if (push && !byte_taken) begin
        next_push = 1'b1;
      end else if (gap_left > 0) begin
        next_push = 1'b0;
        gap_left--;
      end else if (frame_bytes_q.size() > 0) begin
        next_word = frame_bytes_q.pop_front();
        next_push = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                   : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        next_push = 1'b0;
      end
    end
    push    <= next_push;
    in_word <= next_word;
  end

  // Receiver: stall density changes from one random-length stretch to the next,
  // including stretches with no stalls at all and stretches heavy enough to fill the block.
  always @(negedge clk_i) begin : drive_pop
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(100, 600);
    end else begin
      rx_mode_left--;
    end
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      if (rx_mode == 1 && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 8);
      end else if (rx_mode == 2 && $urandom_range(0, 3) != 0) begin
        stall_left = $urandom_range(1, 20);
      end
    end
  end

  always @(posedge clk_i) begin : watch_ports
    out_word_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d verdicts outstanding.",
               cycles, verdicts_due.size());
      $display("ipv4_header_receive_check_tb failed");
      $finish;
    end else if (rst_ni) begin
      byte_taken <= push && !full;
      if (push && !full) begin
        take_frame_byte(in_word);
        bytes_taken++;
      end
      if (pop && !empty) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected result word: verdict %0d, source %h",
                 out_word.verdict, out_word.source_addr);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          verdict_seen[want.verdict]++;
          if (out_word.verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, out_word.verdict);
            mismatches++;
          end
          if (out_word.learn_mapping !== want.learn_mapping) begin
            $error("learn_mapping: expected %0d, got %0d",
                   want.learn_mapping, out_word.learn_mapping);
            mismatches++;
          end
          if (out_word.source_addr !== want.source_addr) begin
            $error("source_addr: expected %h, got %h", want.source_addr,
                   out_word.source_addr);
            mismatches++;
          end
          if (out_word.protocol !== want.protocol) begin
            $error("protocol: expected %0d, got %0d", want.protocol, out_word.protocol);
            mismatches++;
          end
          if (out_word.payload_len !== want.payload_len) begin
            $error("payload_len: expected %0d, got %0d", want.payload_len,
                   out_word.payload_len);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Builds a header with a correct checksum whenever the header length allows one.
  task automatic make_header(input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [15:0] total, input logic [7:0] proto,
                             input logic [31:0] src, input logic [31:0] dst);
    int unsigned n, acc;
    logic [15:0] csum;
    n = (ihl * 4 > MIN_HEADER_BYTES) ? ihl * 4 : MIN_HEADER_BYTES;
    pkt_bytes = {};
    for (int i = 0; i < n; i++) pkt_bytes.push_back(8'($urandom));
    pkt_bytes[0]  = {ver, ihl};
    pkt_bytes[2]  = total[15:8];
    pkt_bytes[3]  = total[7:0];
    pkt_bytes[9]  = proto;
    pkt_bytes[10] = 8'h00;
    pkt_bytes[11] = 8'h00;
    for (int i = 0; i < 4; i++) begin
      pkt_bytes[12 + i] = src[31 - 8 * i -: 8];
      pkt_bytes[16 + i] = dst[31 - 8 * i -: 8];
    end
    if (ihl * 4 >= MIN_HEADER_BYTES) begin
      acc = 0;
      for (int i = 0; i < ihl * 4; i += 2) begin
        acc += {pkt_bytes[i], pkt_bytes[i + 1]};
        if (acc > 32'hffff) acc -= 32'hffff;
      end
      csum          = ~16'(acc);
      pkt_bytes[10] = csum[15:8];
      pkt_bytes[11] = csum[7:0];
    end
  endtask

  task automatic add_payload(input int unsigned n);
    repeat (n) pkt_bytes.push_back(8'($urandom));
  endtask

  task automatic queue_frame();
    in_word_t w;
    foreach (pkt_bytes[i]) begin
      w.frame_byte = pkt_bytes[i];
      w.is_last    = (i == pkt_bytes.size() - 1);
      frame_bytes_q.push_back(w);
    end
    frames_queued++;
    bytes_queued += pkt_bytes.size();
    if (pkt_bytes.size() > longest_frame) longest_frame = pkt_bytes.size();
  endtask

  // Mostly well-formed frames with random content; the rest are broken on purpose.
  task automatic queue_random_frame();
    int unsigned kind, ihl, plen, cut;
    logic [7:0]  proto;
    kind  = $urandom_range(0, 99);
    ihl   = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
    plen  = $urandom_range(0, 12);
    proto = ($urandom_range(0, 2) == 0) ? PROTO_ICMP : 8'($urandom);
    if (kind < 55) begin
      make_header(IP_VERSION4, 4'(ihl), 16'(ihl * 4 + plen), proto, pick_addr(), our_addr);
      add_payload(plen + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0));
    end else if (kind < 63) begin
      make_header(IP_VERSION4, 4'(ihl),
                  $urandom_range(0, 1) ? 16'($urandom_range(0, ihl * 4 - 1))
                                       : 16'(ihl * 4 + plen + $urandom_range(1, 300)),
                  proto, pick_addr(), our_addr);
      add_payload(plen);
    end else if (kind < 70) begin
      make_header(IP_VERSION4, 4'(ihl), 16'(ihl * 4 + plen), proto, pick_addr(),
                  our_addr ^ (32'd1 << $urandom_range(0, 31)));
      add_payload(plen);
    end else if (kind < 80) begin
      make_header(IP_VERSION4, 4'(ihl), 16'(ihl * 4 + plen), proto, pick_addr(), our_addr);
      add_payload(plen);
      cut = $urandom_range(0, ihl * 4 - 1);
      pkt_bytes[cut] ^= 8'(1 << $urandom_range(0, 7));
    end else if (kind < 88) begin
      make_header(IP_VERSION4, 4'(ihl), 16'(ihl * 4 + plen), proto, pick_addr(), our_addr);
      add_payload(plen);
      cut       = $urandom_range(1, pkt_bytes.size());
      pkt_bytes = pkt_bytes[0:cut - 1];
    end else if (kind < 94) begin
      make_header(4'($urandom), 4'($urandom), 16'($urandom), proto, pick_addr(), our_addr);
      add_payload(plen);
    end else begin
      pkt_bytes = {};
      add_payload($urandom_range(1, 30));
    end
    queue_frame();
  endtask

  task automatic random_phase(input int unsigned min_bytes, input int unsigned min_frames);
    int unsigned b0, f0;
    b0 = bytes_queued;
    f0 = frames_queued;
    while (bytes_queued - b0 < min_bytes || frames_queued - f0 < min_frames) begin
      queue_random_frame();
    end
  endtask

  // Waits until every queued byte is sent and every predicted verdict word is popped,
  // then lets the block settle before it counts as idle.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (frame_bytes_q.size() != 0 || push || verdicts_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_local_addr(input logic [31:0] addr);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    our_addr     = addr;
    addr_settings++;
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames with the local address still at its reset value.
    pkt_bytes = {8'hff};
    queue_frame();
    pkt_bytes = {8'h00};
    queue_frame();
    make_header(IP_VERSION4, 4'd5, 16'd20, PROTO_ICMP, 32'h0a000001, our_addr);
    pkt_bytes = pkt_bytes[0:18];
    queue_frame();
    make_header(4'h6, 4'd5, 16'd20, 8'h11, pick_addr(), our_addr);
    queue_frame();
    make_header(4'hf, 4'd5, 16'd20, 8'h11, pick_addr(), our_addr);
    queue_frame();
    make_header(IP_VERSION4, 4'd4, 16'd20, 8'h11, pick_addr(), our_addr);
    queue_frame();
    make_header(IP_VERSION4, 4'd0, 16'd20, 8'h11, pick_addr(), our_addr);
    queue_frame();
    // Header length longer than the frame itself.
    make_header(IP_VERSION4, 4'd15, 16'd60, 8'h11, pick_addr(), our_addr);
    pkt_bytes = pkt_bytes[0:39];
    queue_frame();
    make_header(IP_VERSION4, 4'd5, 16'd28, PROTO_ICMP, '1, our_addr);
    add_payload(8);
    queue_frame();
    make_header(IP_VERSION4, 4'd5, 16'd20, 8'hff, '0, our_addr);
    queue_frame();
    make_header(IP_VERSION4, 4'd15, 16'd64, 8'h00, pick_addr(), our_addr);
    add_payload(4);
    queue_frame();
    make_header(IP_VERSION4, 4'd5, 16'd24, 8'h06, pick_addr(), our_addr);
    add_payload(4);
    pkt_bytes[10] ^= 8'h01;
    queue_frame();
    make_header(IP_VERSION4, 4'd5, 16'd24, 8'h06, pick_addr(), 32'h01020304);
    add_payload(4);
    queue_frame();
    make_header(IP_VERSION4, 4'd5, 16'd19, 8'h06, pick_addr(), our_addr);
    queue_frame();
    make_header(IP_VERSION4, 4'd5, 16'd25, 8'h06, pick_addr(), our_addr);
    add_payload(4);
    queue_frame();
    random_phase(180, 6);
    wait_idle();

    write_local_addr(32'hffffffff);
    make_header(IP_VERSION4, 4'd5, 16'd20, PROTO_ICMP, pick_addr(), 32'h00000000);
    queue_frame();
    make_header(IP_VERSION4, 4'd5, 16'd22, PROTO_ICMP, pick_addr(), our_addr);
    add_payload(2);
    queue_frame();
    random_phase(180, 6);
    wait_idle();

    write_local_addr($urandom);
    random_phase(220, 7);
    wait_idle();

    write_local_addr(32'h00000000);
    random_phase(180, 6);
    wait_idle();

    if (verdicts_due.size() != 0) begin
      $error("%0d expected verdict words never arrived", verdicts_due.size());
      mismatches++;
    end
    $display("Checked %0d verdict words from %0d bytes under %0d local addresses; %s %0d bytes.",
             frames_queued, bytes_taken, addr_settings, "longest frame", longest_frame);
    $display("Verdicts icmp %0d, other %0d, short %0d, version %0d, %s %0d, %0d, %0d, %0d.",
             verdict_seen[VERDICT_ICMP], verdict_seen[VERDICT_OTHER],
             verdict_seen[VERDICT_SHORT], verdict_seen[VERDICT_VERSION],
             "hdr len / checksum / not ours / total len",
             verdict_seen[VERDICT_HDR_LEN], verdict_seen[VERDICT_CHECKSUM],
             verdict_seen[VERDICT_NOT_OURS], verdict_seen[VERDICT_TOTAL_LEN]);
    if (mismatches == 0) begin
      $display("ipv4_header_receive_check_tb passed");
    end else begin
      $display("ipv4_header_receive_check_tb failed");
    end
    $finish;
  end

endmodule
